// ----- sv/pcx_pkg.sv -----
// Shared types and constants for the PCX run-length encoder.
`default_nettype none
package pcx_pkg;

	localparam int MAX_RUN_DEF = 63;
	localparam int QDEPTH_DEF = 4;
	localparam int CNT_W = 6;
	localparam int PIX_W = 8;
	localparam int LEN_W = 16;
	localparam logic [LEN_W-1:0] LINE_LENGTH_RST = 16'd320;
	localparam logic [PIX_W-1:0] RUN_MARK = 8'hC0;

	// up to two closed runs caused by one pixel
	typedef struct packed {
		logic             has_a;
		logic [PIX_W-1:0] val_a;
		logic [CNT_W-1:0] cnt_a;
		logic             has_b;
		logic [PIX_W-1:0] val_b;
		logic [CNT_W-1:0] cnt_b;
	} rec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage
`default_nettype wire

// ----- sv/pcx_front.sv -----
// Front end: accepts pixels, tracks the open run and line position, queues closed runs.
`default_nettype none
module pcx_front #(
	parameter int MAX_RUN = pcx_pkg::MAX_RUN_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [pcx_pkg::LEN_W-1:0] cfg_data,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic [pcx_pkg::PIX_W-1:0] pixel,
	input  wire logic                    last_pixel,
	input  pcx_pkg::q_status_t           q_stat,
	output logic                         q_push,
	output pcx_pkg::rec_t                q_rec
);
	import pcx_pkg::*;

	logic [LEN_W-1:0] line_length_q;
	logic [PIX_W-1:0] run_value_q;
	logic [CNT_W-1:0] run_count_q;
	logic [LEN_W-1:0] line_pos_q;

	logic             accept;
	logic             run_open;
	logic             differ;
	logic [CNT_W-1:0] cnt1;
	logic [PIX_W-1:0] val1;
	logic [LEN_W:0]   pos;
	logic             line_end;
	logic             close_b;

	always_comb begin
		in_stall = q_stat.full;
		accept   = in_valid && !in_stall;
		run_open = (run_count_q != '0);
		differ   = run_open && (pixel != run_value_q);
		if (run_open && !differ) begin
			cnt1 = run_count_q + CNT_W'(1);
			val1 = run_value_q;
		end else begin
			cnt1 = CNT_W'(1);
			val1 = pixel;
		end
		pos      = {1'b0, line_pos_q} + (LEN_W+1)'(1);
		line_end = (pos >= {1'b0, line_length_q});
		close_b  = line_end || (cnt1 >= CNT_W'(MAX_RUN)) || last_pixel;

		q_rec.has_a = differ;
		q_rec.val_a = run_value_q;
		q_rec.cnt_a = run_count_q;
		q_rec.has_b = close_b;
		q_rec.val_b = val1;
		q_rec.cnt_b = cnt1;
		q_push      = accept && (differ || close_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_length_q <= LINE_LENGTH_RST;
			run_value_q   <= '0;
			run_count_q   <= '0;
			line_pos_q    <= '0;
		end else begin
			if (cfg_we) begin
				line_length_q <= cfg_data;
			end
			if (accept) begin
				run_value_q <= val1;
				run_count_q <= close_b ? '0 : cnt1;
				line_pos_q  <= (line_end || last_pixel) ? '0 : pos[LEN_W-1:0];
			end
		end
	end

endmodule
`default_nettype wire

// ----- sv/pcx_fifo.sv -----
// Short queue of closed-run records between front and back end.
`default_nettype none
module pcx_fifo #(
	parameter int QDEPTH = pcx_pkg::QDEPTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  pcx_pkg::rec_t      wr_rec,
	input  wire logic          pop,
	output pcx_pkg::rec_t      rd_rec,
	output pcx_pkg::q_status_t stat
);
	import pcx_pkg::*;

	localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_QW = $clog2(QDEPTH + 1);

	rec_t              mem_q [QDEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_QW-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	always_comb begin
		stat.full  = (count_q == CNT_QW'(QDEPTH));
		stat.empty = (count_q == '0);
		do_push    = push && !stat.full;
		do_pop     = pop && !stat.empty;
		rd_rec     = mem_q[rd_ptr_q];
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_QW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_QW'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ----- sv/pcx_back.sv -----
// Back end: expands queued run records into code bytes, one beat per cycle while out_stall does not hold the output.
`default_nettype none
module pcx_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  pcx_pkg::rec_t      rec,
	input  pcx_pkg::q_status_t q_stat,
	output logic               q_pop,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic [pcx_pkg::PIX_W-1:0] code_byte,
	output logic               step_end
);
	import pcx_pkg::*;

	function automatic logic is_single(input logic [PIX_W-1:0] v, input logic [CNT_W-1:0] c);
		return (c == CNT_W'(1)) && (v < RUN_MARK);
	endfunction

	function automatic logic [PIX_W-1:0] run_byte(input logic [PIX_W-1:0] v,
			input logic [CNT_W-1:0] c, input logic k);
		logic [PIX_W-1:0] r;
		if (is_single(v, c) || k) begin
			r = v;
		end else begin
			r = RUN_MARK | {2'b00, c};
		end
		return r;
	endfunction

	logic [1:0]       phase_q;
	logic             valid_q;
	logic [PIX_W-1:0] byte_q;
	logic             end_q;

	logic [2:0]       na;
	logic [2:0]       nb;
	logic [2:0]       ntot;
	logic [2:0]       idx;
	logic [2:0]       kb;
	logic [PIX_W-1:0] byte_d;
	logic             last_d;
	logic             load;

	always_comb begin
		na     = rec.has_a ? (is_single(rec.val_a, rec.cnt_a) ? 3'd1 : 3'd2) : 3'd0;
		nb     = rec.has_b ? (is_single(rec.val_b, rec.cnt_b) ? 3'd1 : 3'd2) : 3'd0;
		ntot   = na + nb;
		idx    = {1'b0, phase_q};
		kb     = idx - na;
		if (idx < na) begin
			byte_d = run_byte(rec.val_a, rec.cnt_a, idx[0]);
		end else begin
			byte_d = run_byte(rec.val_b, rec.cnt_b, kb[0]);
		end
		last_d = (idx == ntot - 3'd1);
		load   = (!valid_q || !out_stall) && !q_stat.empty;
		q_pop  = load && last_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				phase_q <= last_d ? '0 : phase_q + 2'd1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= byte_d;
			end_q  <= last_d;
		end
	end

	assign out_valid = valid_q;
	assign code_byte = byte_q;
	assign step_end  = end_q;

endmodule
`default_nettype wire

// ----- sv/pcx_rle_encoder.sv -----
// Path: when the queue is empty, a pixel's first code byte passes through the run queue and
// then the output register before it can be taken.
// Throughput: one pixel per cycle while the output keeps up; output runs at one
// byte per cycle, so pixels closing two-byte or double runs are paced by the
// byte expander draining the run queue; pixels stall while the queue holds QDEPTH records.
// Reset: line_length 320, no run open, line position zero, queue and output empty.
`default_nettype none
module pcx_rle_encoder #(
	parameter int MAX_RUN = pcx_pkg::MAX_RUN_DEF,
	parameter int QDEPTH  = pcx_pkg::QDEPTH_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [pcx_pkg::LEN_W-1:0] line_length,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic [pcx_pkg::PIX_W-1:0] pixel,
	input  wire logic                    last_pixel,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic [pcx_pkg::PIX_W-1:0]    code_byte,
	output logic                         step_end
);
	import pcx_pkg::*;

	q_status_t q_stat;
	rec_t      push_rec;
	rec_t      head_rec;
	logic      q_push;
	logic      q_pop;
	logic      cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	pcx_front #(.MAX_RUN(MAX_RUN)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (line_length),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pixel     (pixel),
		.last_pixel(last_pixel),
		.q_stat    (q_stat),
		.q_push    (q_push),
		.q_rec     (push_rec)
	);

	pcx_fifo #(.QDEPTH(QDEPTH)) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wr_rec(push_rec),
		.pop   (q_pop),
		.rd_rec(head_rec),
		.stat  (q_stat)
	);

	pcx_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rec      (head_rec),
		.q_stat   (q_stat),
		.q_pop    (q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.code_byte(code_byte),
		.step_end (step_end)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_stat.full))
		else $error("run queue written while full");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_pop && q_stat.empty))
		else $error("run queue read while empty");

	a_rec_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (push_rec.has_a || push_rec.has_b))
		else $error("queued record closes no run");

	a_pop_marks_end: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (out_valid && step_end))
		else $error("record retired without a step_end beat");

endmodule
`default_nettype wire

// ----- bench/pcx_rle_checker.sv -----
// Bus monitor for the PCX RLE encoder: models the coder and checks every code byte.
module pcx_rle_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [pcx_pkg::LEN_W-1:0] line_length,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  logic [pcx_pkg::PIX_W-1:0] pixel,
	input  logic                      last_pixel,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  logic [pcx_pkg::PIX_W-1:0] code_byte,
	input  logic                      step_end,
	output int                        fail_count,
	output int                        pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import pcx_pkg::*;

	typedef struct packed {
		logic [PIX_W-1:0] code;
		logic             fin;
	} code_beat_t;

	code_beat_t       pending_codes[$];
	code_beat_t       step_codes[$];
	logic [LEN_W-1:0] line_len;
	logic [LEN_W-1:0] line_pos;
	logic [PIX_W-1:0] run_val;
	logic [CNT_W-1:0] run_len;

	function automatic void close_run();
		if (run_len == 0)
			return;
		if (run_len == 1 && run_val < RUN_MARK) begin
			step_codes.push_back('{run_val, 1'b0});
		end else begin
			step_codes.push_back('{RUN_MARK | PIX_W'(run_len), 1'b0});
			step_codes.push_back('{run_val, 1'b0});
		end
		run_len = '0;
	endfunction

	function automatic void encode_pixel(logic [PIX_W-1:0] pix, logic last);
		logic [LEN_W:0] pos;
		step_codes.delete();
		if (run_len != 0 && pix != run_val)
			close_run();
		if (run_len == 0) begin
			run_val = pix;
			run_len = CNT_W'(1);
		end else begin
			run_len = run_len + CNT_W'(1);
		end
		pos = {1'b0, line_pos} + (LEN_W+1)'(1);
		if (pos >= {1'b0, line_len}) begin
			close_run();
			pos = '0;
		end else if (run_len >= MAX_RUN_DEF) begin
			close_run();
		end
		line_pos = pos[LEN_W-1:0];
		if (last) begin
			close_run();
			line_pos = '0;
		end
		if (step_codes.size() > 0)
			step_codes[step_codes.size()-1].fin = 1'b1;
		foreach (step_codes[i])
			pending_codes.push_back(step_codes[i]);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		code_beat_t exp_beat;
		if (!arst_n) begin
			pending_codes.delete();
			line_len = LINE_LENGTH_RST;
			line_pos = '0;
			run_val = '0;
			run_len = '0;
			fail_count = 0;
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_codes.size() == 0) begin
					$error("code_byte: nothing expected, got %0h", code_byte);
					fail_count++;
				end else begin
					exp_beat = pending_codes.pop_front();
					if (code_byte !== exp_beat.code) begin
						$error("code_byte: expected %0h, got %0h", exp_beat.code, code_byte);
						fail_count++;
					end
					if (step_end !== exp_beat.fin) begin
						$error("step_end: expected %0b, got %0b", exp_beat.fin, step_end);
						fail_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				line_len = line_length;
			if (in_valid && !in_stall)
				encode_pixel(pixel, last_pixel);
			pending = pending_codes.size();
		end
	end

endmodule

// ----- bench/tb_pcx_rle_encoder.sv -----
// Top-level bench for the PCX RLE encoder: reset, stimulus, idling and verdict.
module tb_pcx_rle_encoder;
	timeunit 1ns;
	timeprecision 1ps;
	import pcx_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [LEN_W-1:0] line_length;
	logic             in_valid;
	logic             in_stall;
	logic [PIX_W-1:0] pixel;
	logic             last_pixel;
	logic             out_valid;
	logic             out_stall;
	logic [PIX_W-1:0] code_byte;
	logic             step_end;
	int               fails;
	int               pending;
	int               cycles = 0;
	int               tx_pct = 0;
	int               rx_pct = 0;

	pcx_rle_encoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.line_length(line_length),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.pixel      (pixel),
		.last_pixel (last_pixel),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.code_byte  (code_byte),
		.step_end   (step_end)
	);

	pcx_rle_checker rle_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.line_length(line_length),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.pixel      (pixel),
		.last_pixel (last_pixel),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.code_byte  (code_byte),
		.step_end   (step_end),
		.fail_count (fails),
		.pending    (pending)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL pcx_rle_encoder");
			$finish;
		end
	end

	always @(negedge clk)
		out_stall <= ($urandom_range(99) < rx_pct);

	task automatic set_idling(input int mode);
		case (mode)
			0: begin
				tx_pct = 18;
				rx_pct = 83;
			end
			1: begin
				tx_pct = 83;
				rx_pct = 18;
			end
			default: begin
				tx_pct = 0;
				rx_pct = 0;
			end
		endcase
	endtask

	task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic last);
		while ($urandom_range(99) < tx_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		pixel      <= pix;
		last_pixel <= last;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// let the coder empty out, then wait on for pixels that emit nothing
	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_line_length(input logic [LEN_W-1:0] len);
		cfg_valid   <= 1'b1;
		line_length <= len;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_random(input logic [LEN_W-1:0] len, input int count, input int burst);
		logic [PIX_W-1:0] prev;
		int               burst_left;
		int               r;
		write_line_length(len);
		prev = PIX_W'($urandom_range(255));
		burst_left = burst;
		repeat (count) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				r = $urandom_range(99);
				if (r < 3) begin
					burst_left = $urandom_range(20, 5);
				end else if (r < 45) begin
					// repeat previous pixel, keeps runs going
				end else if (r < 60) begin
					case ($urandom_range(3))
						0: prev = 8'h00;
						1: prev = 8'hBF;
						2: prev = 8'hC0;
						default: prev = 8'hFF;
					endcase
				end else if (r < 80) begin
					prev = PIX_W'($urandom_range(255, 192));
				end else begin
					prev = PIX_W'($urandom_range(255));
				end
			end
			send_pixel(prev, burst_left == 0 && $urandom_range(99) < 4);
		end
		drain();
	endtask

	initial begin
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		line_length = '0;
		in_valid    = 1'b0;
		pixel       = '0;
		last_pixel  = 1'b0;
		out_stall   = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// singles, escapes, short runs at the reset line length
		set_idling(0);
		send_pixel(8'h00, 1'b0);
		send_pixel(8'hFF, 1'b0);
		send_pixel(8'hBF, 1'b0);
		send_pixel(8'hC0, 1'b0);
		send_pixel(8'h05, 1'b0);
		send_pixel(8'h05, 1'b0);
		send_pixel(8'h07, 1'b1);
		send_pixel(8'hC8, 1'b0);
		send_pixel(8'hC8, 1'b1);
		drain();

		// two runs closed by one pixel at a line end: four bytes
		write_line_length(16'd3);
		send_pixel(8'hC5, 1'b0);
		send_pixel(8'hC5, 1'b0);
		send_pixel(8'hFE, 1'b0);
		drain();

		// zero length behaves as one pixel per line
		write_line_length(16'd0);
		send_pixel(8'h01, 1'b0);
		send_pixel(8'h01, 1'b0);
		send_pixel(8'h02, 1'b1);
		drain();

		// shrink the line below the current position
		write_line_length(16'd8);
		repeat (5) send_pixel(8'h04, 1'b0);
		drain();
		write_line_length(16'd2);
		send_pixel(8'h04, 1'b0);
		send_pixel(8'h06, 1'b1);
		drain();

		run_random(16'd65535, 80, 64);
		run_random(16'd1, 11, 0);
		set_idling(1);
		run_random(16'd17, 11, 0);
		run_random(16'd320, 11, 0);
		run_random(16'd64, 11, 0);
		set_idling(2);
		run_random(16'd2, 11, 0);
		run_random(16'd63, 11, 0);

		if (fails == 0)
			$display("PASS pcx_rle_encoder");
		else
			$display("FAIL pcx_rle_encoder");
		$finish;
	end

endmodule
